// ===== hdl/lmrg_pkg.sv =====
// ----------------------------------------------------------------------------
// lmrg_pkg
// shared types and constants of the lehmer modular random generator
// ----------------------------------------------------------------------------
package lmrg_pkg;

    localparam int VAL_W     = 31;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int CNT_W     = $clog2(PROD_W);
    localparam int CFG_IDX_W = 2;

    localparam logic [VAL_W-1:0] MULT_RESET = VAL_W'(16807);
    localparam logic [VAL_W-1:0] MOD_RESET  = VAL_W'(2147483647);
    localparam logic [VAL_W-1:0] SEED_RESET = VAL_W'(1);

    // item commands
    localparam logic CMD_DRAW = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MULT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MOD  = CFG_IDX_W'(1);

    typedef struct packed {
        logic             cmd;
        logic [VAL_W-1:0] seed_value;
    } t_in;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             seed_error;
    } t_out;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [VAL_W-1:0]     data;
    } t_cfg_wr;

    // controller to datapath commands
    typedef struct packed {
        logic take;
        logic mul;
        logic red;
        logic fin;
        logic out_load;
    } t_dp_cmd;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_RED  = 5'b00100,
        ST_FIN  = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

endpackage

// ===== hdl/lmrg_dp.sv =====
// ----------------------------------------------------------------------------
// lmrg_dp
// seed, config registers, multiplier and bit-serial modular reduction
// ----------------------------------------------------------------------------
module lmrg_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lmrg_pkg::t_dp_cmd i_cmd,
    input  lmrg_pkg::t_in    i_in,
    input  lmrg_pkg::t_cfg_wr i_cfg,
    output lmrg_pkg::t_out   o_out
);

    logic [lmrg_pkg::VAL_W-1:0]  r_mult;
    logic [lmrg_pkg::VAL_W-1:0]  r_mod;
    logic [lmrg_pkg::VAL_W-1:0]  r_seed;
    logic                        r_err;
    logic [lmrg_pkg::PROD_W-1:0] r_prod;
    logic [lmrg_pkg::VAL_W-1:0]  r_low;
    logic [lmrg_pkg::VAL_W-1:0]  r_rem;
    lmrg_pkg::t_out              r_out;

    logic [lmrg_pkg::PROD_W-1:0] n_prod;
    logic [lmrg_pkg::VAL_W:0]    w_shift;
    logic [lmrg_pkg::VAL_W:0]    w_mod_ext;
    logic [lmrg_pkg::VAL_W:0]    w_diff;
    logic [lmrg_pkg::VAL_W-1:0]  n_rem;
    logic                        w_mod_zero;

    assign n_prod     = lmrg_pkg::PROD_W'(r_mult) * lmrg_pkg::PROD_W'(r_seed);
    assign w_shift    = {r_rem, r_prod[lmrg_pkg::PROD_W-1]};
    assign w_mod_ext  = {1'b0, r_mod};
    assign w_diff     = w_shift - w_mod_ext;
    assign n_rem      = (w_shift >= w_mod_ext) ? w_diff[lmrg_pkg::VAL_W-1:0]
                                               : w_shift[lmrg_pkg::VAL_W-1:0];
    assign w_mod_zero = (r_mod == '0);

    // control state: config and seed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult <= lmrg_pkg::MULT_RESET;
            r_mod  <= lmrg_pkg::MOD_RESET;
            r_seed <= lmrg_pkg::SEED_RESET;
        end else begin
            if (i_cfg.we && i_cfg.index == lmrg_pkg::REG_MULT) begin
                r_mult <= i_cfg.data;
            end
            if (i_cfg.we && i_cfg.index == lmrg_pkg::REG_MOD) begin
                r_mod <= i_cfg.data;
            end
            if (i_cmd.take && i_in.cmd == lmrg_pkg::CMD_LOAD && i_in.seed_value != '0) begin
                r_seed <= i_in.seed_value;
            end else if (i_cmd.fin) begin
                r_seed <= w_mod_zero ? r_low : r_rem;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_err <= (i_in.cmd == lmrg_pkg::CMD_LOAD) && (i_in.seed_value == '0);
        end
        if (i_cmd.mul) begin
            r_prod <= n_prod;
            r_low  <= n_prod[lmrg_pkg::VAL_W-1:0];
            r_rem  <= '0;
        end else if (i_cmd.red) begin
            r_prod <= {r_prod[lmrg_pkg::PROD_W-2:0], 1'b0};
            r_rem  <= n_rem;
        end
        if (i_cmd.out_load) begin
            r_out.value      <= r_seed;
            r_out.seed_error <= r_err;
        end
    end

    assign o_out = r_out;

    a_rem_below_mod : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.red |=> (r_rem < r_mod) || w_mod_zero)
        else $error("remainder not below modulus");

    a_draw_below_mod : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fin && !w_mod_zero) |=> (r_seed < r_mod))
        else $error("drawn seed not below modulus");

endmodule

// ===== hdl/lmrg_ctrl.sv =====
// ----------------------------------------------------------------------------
// lmrg_ctrl
// sequencer for load and draw items and the output register handshake
// ----------------------------------------------------------------------------
module lmrg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_cmd,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output lmrg_pkg::t_dp_cmd o_cmd
);

    lmrg_pkg::t_state           r_state, n_state;
    logic [lmrg_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                       r_out_valid;
    logic                       w_accept;
    logic                       w_last;

    assign o_in_ready = (r_state == lmrg_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_last     = (r_cnt == lmrg_pkg::CNT_W'(lmrg_pkg::PROD_W - 1));

    always_comb begin
        o_cmd.take     = w_accept;
        o_cmd.mul      = (r_state == lmrg_pkg::ST_MUL);
        o_cmd.red      = (r_state == lmrg_pkg::ST_RED);
        o_cmd.fin      = (r_state == lmrg_pkg::ST_FIN);
        o_cmd.out_load = (r_state == lmrg_pkg::ST_DONE) && (!r_out_valid || i_out_ready);
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            lmrg_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in_cmd == lmrg_pkg::CMD_LOAD) ? lmrg_pkg::ST_DONE
                                                               : lmrg_pkg::ST_MUL;
                end
            end
            lmrg_pkg::ST_MUL: begin
                n_cnt   = '0;
                n_state = lmrg_pkg::ST_RED;
            end
            lmrg_pkg::ST_RED: begin
                n_cnt = r_cnt + 1'b1;
                if (w_last) begin
                    n_state = lmrg_pkg::ST_FIN;
                end
            end
            lmrg_pkg::ST_FIN: begin
                n_state = lmrg_pkg::ST_DONE;
            end
            lmrg_pkg::ST_DONE: begin
                if (o_cmd.out_load) begin
                    n_state = lmrg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lmrg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lmrg_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("input taken twice in a row");

    a_cnt_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lmrg_pkg::ST_RED) |-> (r_cnt < lmrg_pkg::CNT_W'(lmrg_pkg::PROD_W)))
        else $error("reduction counter overran");

    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("pending result overwritten");

endmodule

// ===== hdl/lehmer_modular_random_generator.sv =====
// ----------------------------------------------------------------------------
// lehmer_modular_random_generator
// multiplicative congruential generator, seed <= (multiplier * seed) mod modulus
// ----------------------------------------------------------------------------
// draw: 62-bit product, then a 62-step bit-serial reduction and the seed update;
//   modulus 0 gives the product mod 2^31
// load: no arithmetic; next item taken once the output register holds the result
// reset (synchronous, active low): seed 1, multiplier 16807, modulus 2^31-1,
//   no result pending; config writes are taken every cycle
module lehmer_modular_random_generator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // item input
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  lmrg_pkg::t_in                     i_in_data,
    // result output
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output lmrg_pkg::t_out                    o_out_data,
    // config write
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lmrg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lmrg_pkg::VAL_W-1:0]        i_cfg_data
);

    lmrg_pkg::t_dp_cmd w_cmd;
    lmrg_pkg::t_cfg_wr w_cfg;

    // config beats are taken in any cycle; writes to unknown indexes drop out
    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_cfg.we    = i_cfg_valid;
        w_cfg.index = i_cfg_index;
        w_cfg.data  = i_cfg_data;
    end

    // sequencer: one item at a time, result parked in the output register
    lmrg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_cmd    (i_in_data.cmd),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    // seed, multiply, shift-subtract remainder, output register
    lmrg_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_in    (i_in_data),
        .i_cfg   (w_cfg),
        .o_out   (o_out_data)
    );

endmodule

// ===== dv/lehmer_modular_random_generator_tb.sv =====
// ----------------------------------------------------------------------------
// lehmer_modular_random_generator_tb
// self-checking bench: directed seed loads and draws, then random command
// streams under several multiplier/modulus settings and handshake pacings
// ----------------------------------------------------------------------------
module lehmer_modular_random_generator_tb ();

    localparam int          CLK_PERIOD   = 10;
    localparam int          RESET_CYCLES = 5;
    localparam int          DRAIN_CYCLES = 80;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int          PHASES       = 9;
    localparam int          PHASE_ITEMS  = 100;
    localparam int          LOAD_PCT     = 25;

    // register indexes past the end of the register list, writes are dropped
    localparam logic [lmrg_pkg::CFG_IDX_W-1:0] REG_NONE_LO = lmrg_pkg::CFG_IDX_W'(2);
    localparam logic [lmrg_pkg::CFG_IDX_W-1:0] REG_NONE_HI = lmrg_pkg::CFG_IDX_W'(3);

    localparam logic [lmrg_pkg::VAL_W-1:0] VAL_MAX = {lmrg_pkg::VAL_W{1'b1}};

    // ------------------------------------------------------------------------
    // seed tracker: mirrors multiplier, modulus and seed, holds expected results
    // ------------------------------------------------------------------------
    class seed_sequence_checker;
        logic [lmrg_pkg::VAL_W-1:0] mult_reg;
        logic [lmrg_pkg::VAL_W-1:0] mod_reg;
        logic [lmrg_pkg::VAL_W-1:0] cur_seed;
        lmrg_pkg::t_out             expected_results[$];
        int                         mismatches;

        function new();
            mult_reg   = lmrg_pkg::MULT_RESET;
            mod_reg    = lmrg_pkg::MOD_RESET;
            cur_seed   = lmrg_pkg::SEED_RESET;
            mismatches = 0;
        endfunction

        function void write_reg(logic [lmrg_pkg::CFG_IDX_W-1:0] idx,
                                logic [lmrg_pkg::VAL_W-1:0] data);
            case (idx)
                lmrg_pkg::REG_MULT: mult_reg = data;
                lmrg_pkg::REG_MOD:  mod_reg  = data;
                default:  ;
            endcase
        endfunction

        // exact reduction of the full product, modulus zero means mod 2^31
        function logic [lmrg_pkg::VAL_W-1:0] next_seed(logic [lmrg_pkg::VAL_W-1:0] s);
            logic [lmrg_pkg::PROD_W-1:0] prod;
            prod = lmrg_pkg::PROD_W'(mult_reg) * lmrg_pkg::PROD_W'(s);
            if (mod_reg == '0) begin
                return prod[lmrg_pkg::VAL_W-1:0];
            end
            return lmrg_pkg::VAL_W'(prod % lmrg_pkg::PROD_W'(mod_reg));
        endfunction

        function void note_item(lmrg_pkg::t_in item);
            lmrg_pkg::t_out want;
            want.seed_error = 1'b0;
            if (item.cmd == lmrg_pkg::CMD_DRAW) begin
                cur_seed = next_seed(cur_seed);
            end else if (item.seed_value == '0) begin
                want.seed_error = 1'b1;     // zero seed refused, seed kept
            end else begin
                cur_seed = item.seed_value;
            end
            want.value = cur_seed;
            expected_results.push_back(want);
        endfunction

        function void check_result(lmrg_pkg::t_out got);
            lmrg_pkg::t_out want;
            if (expected_results.size() == 0) begin
                $error("result beat with nothing outstanding: value %0d seed_error %0d",
                       got.value, got.seed_error);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            if (got.value !== want.value) begin
                $error("value mismatch: expected %0d, got %0d", want.value, got.value);
                mismatches++;
            end
            if (got.seed_error !== want.seed_error) begin
                $error("seed_error mismatch: expected %0d, got %0d",
                       want.seed_error, got.seed_error);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, dut hookup
    // ------------------------------------------------------------------------
    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    lmrg_pkg::t_in                  in_data   = '0;
    logic                           out_ready = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic [lmrg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [lmrg_pkg::VAL_W-1:0]     cfg_data  = '0;

    logic                           in_ready;
    logic                           out_valid;
    lmrg_pkg::t_out                 out_data;
    logic                           cfg_ready;

    int unsigned                    snd_idle_pct = 0;
    int unsigned                    rcv_idle_pct = 0;
    int unsigned                    cycle_count  = 0;

    seed_sequence_checker seq_chk = new();

    always #(CLK_PERIOD / 2) clk = ~clk;

    lehmer_modular_random_generator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // receiver backpressure, redrawn every cycle at the current stall rate
    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // monitor: all three channels sampled on the rising edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                seq_chk.write_reg(cfg_index, cfg_data);
            end
            if (in_valid && in_ready) begin
                seq_chk.note_item(in_data);
            end
            if (out_valid && out_ready) begin
                seq_chk.check_result(out_data);
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[lehmer_modular_random_generator] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // drivers, every task starts and ends on a falling edge
    // ------------------------------------------------------------------------

    // valid stays high across back-to-back beats, dropped only on a gap
    task automatic send_item(input lmrg_pkg::t_in item);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic stop_items();
        in_valid <= 1'b0;
    endtask

    // config valid is left high so consecutive writes go out back to back
    task automatic cfg_write(input logic [lmrg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lmrg_pkg::VAL_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic apply_config(input logic [lmrg_pkg::VAL_W-1:0] mult,
                                input logic [lmrg_pkg::VAL_W-1:0] modv,
                                input logic [lmrg_pkg::CFG_IDX_W-1:0] spare_idx);
        cfg_write(spare_idx, lmrg_pkg::VAL_W'($urandom()));   // must be dropped
        cfg_write(lmrg_pkg::REG_MULT, mult);
        cfg_write(lmrg_pkg::REG_MOD, modv);
        cfg_valid <= 1'b0;
    endtask

    // block is idle once every outstanding result has been taken
    task automatic wait_drained();
        while (seq_chk.pending() != 0) begin
            @(negedge clk);
        end
    endtask

    function automatic lmrg_pkg::t_in make_item(input logic cmd,
                                                input logic [lmrg_pkg::VAL_W-1:0] seed);
        lmrg_pkg::t_in item;
        item.cmd        = cmd;
        item.seed_value = seed;
        return item;
    endfunction

    // mostly draws; load seeds lean on zero, all ones, tiny values and the modulus
    function automatic lmrg_pkg::t_in random_item();
        lmrg_pkg::t_in item;
        int unsigned   pick;
        item.cmd = ($urandom_range(99) < LOAD_PCT) ? lmrg_pkg::CMD_LOAD : lmrg_pkg::CMD_DRAW;
        pick = $urandom_range(15);
        case (pick)
            0:       item.seed_value = '0;
            1:       item.seed_value = VAL_MAX;
            2:       item.seed_value = seq_chk.mod_reg;
            3:       item.seed_value = lmrg_pkg::VAL_W'($urandom_range(1, 16));
            default: item.seed_value = lmrg_pkg::VAL_W'($urandom());
        endcase
        return item;
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [lmrg_pkg::VAL_W-1:0]     mult_set;
        logic [lmrg_pkg::VAL_W-1:0]     mod_set;
        logic [lmrg_pkg::CFG_IDX_W-1:0] spare_idx;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part at reset settings (16807, 2^31-1), seed starts at 1
        snd_idle_pct = 20;
        rcv_idle_pct = 51;
        send_item(make_item(lmrg_pkg::CMD_DRAW, '0));
        // draw ignores the seed field
        send_item(make_item(lmrg_pkg::CMD_DRAW, VAL_MAX));
        // zero seed refused
        send_item(make_item(lmrg_pkg::CMD_LOAD, '0));
        // seed equal to modulus kept as is
        send_item(make_item(lmrg_pkg::CMD_LOAD, VAL_MAX));
        // reduces to zero
        send_item(make_item(lmrg_pkg::CMD_DRAW, '0));
        // stuck at zero
        send_item(make_item(lmrg_pkg::CMD_DRAW, lmrg_pkg::VAL_W'(31'h2AAA_AAAA)));
        // refused while seed is zero
        send_item(make_item(lmrg_pkg::CMD_LOAD, '0));
        send_item(make_item(lmrg_pkg::CMD_LOAD, lmrg_pkg::VAL_W'(1)));
        send_item(make_item(lmrg_pkg::CMD_DRAW, lmrg_pkg::VAL_W'(31'h5555_5555)));
        send_item(make_item(lmrg_pkg::CMD_LOAD, lmrg_pkg::VAL_W'(31'h2AAA_AAAA)));
        send_item(make_item(lmrg_pkg::CMD_LOAD, lmrg_pkg::VAL_W'(31'h5555_5555)));
        send_item(make_item(lmrg_pkg::CMD_DRAW, '0));
        // largest legal seed
        send_item(make_item(lmrg_pkg::CMD_LOAD, lmrg_pkg::MOD_RESET - lmrg_pkg::VAL_W'(1)));
        send_item(make_item(lmrg_pkg::CMD_DRAW, '0));
        send_item(make_item(lmrg_pkg::CMD_DRAW, '0));
        send_item(make_item(lmrg_pkg::CMD_LOAD, '0));
        stop_items();
        wait_drained();

        // random part: one register setting per phase, pacing changes every 3
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph / 3)
                0: begin
                    snd_idle_pct = 20;
                    rcv_idle_pct = 51;
                end
                1: begin
                    snd_idle_pct = 51;
                    rcv_idle_pct = 20;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase

            case (ph)
                0: begin                                    // minstd revised multiplier
                    mult_set = lmrg_pkg::VAL_W'(48271);
                    mod_set  = lmrg_pkg::MOD_RESET;
                end
                1: begin                                    // both at maximum
                    mult_set = VAL_MAX;
                    mod_set  = VAL_MAX;
                end
                2: begin                                    // identity multiplier, modulus two
                    mult_set = lmrg_pkg::VAL_W'(1);
                    mod_set  = lmrg_pkg::VAL_W'(2);
                end
                3: begin                                    // zero multiplier
                    mult_set = '0;
                    mod_set  = lmrg_pkg::VAL_W'($urandom_range(2, 2147483647));
                end
                4: begin                                    // zero modulus, wraps mod 2^31
                    mult_set = lmrg_pkg::VAL_W'($urandom());
                    mod_set  = '0;
                end
                5: begin                                    // modulus one, draws give zero
                    mult_set = lmrg_pkg::VAL_W'($urandom());
                    mod_set  = lmrg_pkg::VAL_W'(1);
                end
                6: begin
                    mult_set = lmrg_pkg::VAL_W'($urandom());
                    mod_set  = lmrg_pkg::VAL_W'($urandom());
                end
                7: begin                                    // back to the classic setting
                    mult_set = lmrg_pkg::MULT_RESET;
                    mod_set  = lmrg_pkg::MOD_RESET;
                end
                default: begin                              // small modulus
                    mult_set = lmrg_pkg::VAL_W'($urandom());
                    mod_set  = lmrg_pkg::VAL_W'($urandom_range(2, 64));
                end
            endcase

            spare_idx = ph[0] ? REG_NONE_HI : REG_NONE_LO;
            apply_config(mult_set, mod_set, spare_idx);
            @(negedge clk);

            repeat (PHASE_ITEMS) send_item(random_item());
            stop_items();
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (seq_chk.mismatches == 0 && seq_chk.pending() == 0) begin
            $display("[lehmer_modular_random_generator] OK");
        end else begin
            $display("[lehmer_modular_random_generator] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/lmrg_pkg.sv
hdl/lmrg_dp.sv
hdl/lmrg_ctrl.sv
hdl/lehmer_modular_random_generator.sv
dv/lehmer_modular_random_generator_tb.sv
